[hdl/rrpt_pkg.sv]
// Shared types, constants and the step microprogram of the Rossler RK4 peak tracker.
// Depends on nothing; every other file of the block imports it.
package rrpt_pkg;

    // Fixed-point format: signed Q8.24
    localparam int DW = 32;
    localparam int FB = 24;

    // Widths of the datapath
    localparam int PROD_W   = 2 * (DW + 1);
    localparam int SQ_SHIFT = 3;
    localparam int NUM_W    = 2 * DW - SQ_SHIFT;
    localparam int DEN_W    = DW + 2;

    // Configuration register widths
    localparam int GAIN_W     = 27;
    localparam int STEP_SZ_W  = 24;
    localparam int AXIS_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_C_GAIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_A_GAIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_B_OFFSET = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS     = 3'd4;

    localparam logic [GAIN_W-1:0]    C_RESET    = 27'd41943040;
    localparam logic [GAIN_W-1:0]    A_RESET    = 27'd3355443;
    localparam logic [GAIN_W-1:0]    B_RESET    = 27'd3355443;
    localparam logic [STEP_SZ_W-1:0] STEP_RESET = 24'd167772;

    localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

    // h/6 as a multiply by a rounded-up reciprocal and a shift
    localparam int H6_SHIFT = STEP_SZ_W + 2;
    localparam int K6_INT   = ((1 << H6_SHIFT) + 5) / 6;
    localparam logic [STEP_SZ_W-1:0] K6_CONST = STEP_SZ_W'(K6_INT);

    localparam logic [DW-1:0] MAX_POS = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] MAX_NEG = {1'b1, {(DW-1){1'b0}}};
    localparam logic signed [PROD_W-1:0] WIDE_HI = {{(PROD_W-DW+1){1'b0}}, {(DW-1){1'b1}}};
    localparam logic signed [PROD_W-1:0] WIDE_LO = ~WIDE_HI;

    // Shared unit opcodes
    localparam int OPC_W = 3;
    localparam logic [OPC_W-1:0] OP_ADD  = 3'd0;
    localparam logic [OPC_W-1:0] OP_SUB  = 3'd1;
    localparam logic [OPC_W-1:0] OP_MUL  = 3'd2;
    localparam logic [OPC_W-1:0] OP_MULK = 3'd3;
    localparam logic [OPC_W-1:0] OP_SQ   = 3'd4;

    // Operand and destination codes
    localparam int SEL_W = 5;
    localparam logic [SEL_W-1:0] R_ZERO = 5'd0;
    localparam logic [SEL_W-1:0] R_PX   = 5'd1;
    localparam logic [SEL_W-1:0] R_PY   = 5'd2;
    localparam logic [SEL_W-1:0] R_PZ   = 5'd3;
    localparam logic [SEL_W-1:0] R_TX   = 5'd4;
    localparam logic [SEL_W-1:0] R_TY   = 5'd5;
    localparam logic [SEL_W-1:0] R_TZ   = 5'd6;
    localparam logic [SEL_W-1:0] R_KX   = 5'd7;
    localparam logic [SEL_W-1:0] R_KY   = 5'd8;
    localparam logic [SEL_W-1:0] R_KZ   = 5'd9;
    localparam logic [SEL_W-1:0] R_QX   = 5'd10;
    localparam logic [SEL_W-1:0] R_QY   = 5'd11;
    localparam logic [SEL_W-1:0] R_QZ   = 5'd12;
    localparam logic [SEL_W-1:0] R_SX   = 5'd13;
    localparam logic [SEL_W-1:0] R_SY   = 5'd14;
    localparam logic [SEL_W-1:0] R_SZ   = 5'd15;
    localparam logic [SEL_W-1:0] R_M    = 5'd16;
    localparam logic [SEL_W-1:0] R_A    = 5'd17;
    localparam logic [SEL_W-1:0] R_B    = 5'd18;
    localparam logic [SEL_W-1:0] R_C    = 5'd19;
    localparam logic [SEL_W-1:0] R_H    = 5'd20;
    localparam logic [SEL_W-1:0] R_H2   = 5'd21;
    localparam logic [SEL_W-1:0] R_H6   = 5'd22;
    localparam logic [SEL_W-1:0] R_K6   = 5'd23;

    localparam int STEP_W = 7;
    localparam logic [STEP_W-1:0] LAST_STEP = 7'd70;

    typedef struct packed {
        logic              op;
        logic signed [DW-1:0] init_x;
        logic signed [DW-1:0] init_y;
        logic signed [DW-1:0] init_z;
    } in_item_t;

    typedef struct packed {
        logic signed [DW-1:0] new_x;
        logic signed [DW-1:0] new_y;
        logic signed [DW-1:0] new_z;
        logic                 peak_found;
        logic signed [DW-1:0] peak_value;
        logic                 overflow;
    } out_item_t;

    typedef struct packed {
        logic [OPC_W-1:0] opc;
        logic [SEL_W-1:0] sa;
        logic [SEL_W-1:0] sb;
        logic [SEL_W-1:0] dst;
    } uop_t;

    typedef struct packed {
        logic [OPC_W-1:0]   opc;
        logic signed [DW:0] a;
        logic signed [DW:0] b;
    } alu_req_t;

    typedef struct packed {
        logic signed [DW-1:0] res;
        logic                 ovf;
        logic [PROD_W-1:0]    prod;
    } alu_rsp_t;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quo;
    } div_rsp_t;

    // Saturate a wide signed value to DW bits; top bit flags saturation
    function automatic logic [DW:0] sat_wide(input logic signed [PROD_W-1:0] v);
        logic [DW:0] r;
        if (v > WIDE_HI) begin
            r = {1'b1, MAX_POS};
        end else if (v < WIDE_LO) begin
            r = {1'b1, MAX_NEG};
        end else begin
            r = {1'b0, v[DW-1:0]};
        end
        return r;
    endfunction

    // One RK4 step as a sequence of operations on the shared unit
    function automatic uop_t prog_rom(input logic [STEP_W-1:0] step);
        uop_t u;
        case (step)
            7'd0:  u = '{OP_MULK, R_H,    R_K6,   R_H6};
            // slope k1
            7'd1:  u = '{OP_SUB,  R_ZERO, R_TY,   R_M};
            7'd2:  u = '{OP_SUB,  R_M,    R_TZ,   R_KX};
            7'd3:  u = '{OP_MUL,  R_A,    R_TY,   R_M};
            7'd4:  u = '{OP_ADD,  R_TX,   R_M,    R_KY};
            7'd5:  u = '{OP_SUB,  R_TX,   R_C,    R_M};
            7'd6:  u = '{OP_MUL,  R_TZ,   R_M,    R_M};
            7'd7:  u = '{OP_ADD,  R_B,    R_M,    R_KZ};
            7'd8:  u = '{OP_ADD,  R_KX,   R_ZERO, R_QX};
            7'd9:  u = '{OP_ADD,  R_KY,   R_ZERO, R_QY};
            7'd10: u = '{OP_ADD,  R_KZ,   R_ZERO, R_QZ};
            7'd11: u = '{OP_MUL,  R_H2,   R_KX,   R_M};
            7'd12: u = '{OP_ADD,  R_PX,   R_M,    R_TX};
            7'd13: u = '{OP_MUL,  R_H2,   R_KY,   R_M};
            7'd14: u = '{OP_ADD,  R_PY,   R_M,    R_TY};
            7'd15: u = '{OP_MUL,  R_H2,   R_KZ,   R_M};
            7'd16: u = '{OP_ADD,  R_PZ,   R_M,    R_TZ};
            // slope k2
            7'd17: u = '{OP_SUB,  R_ZERO, R_TY,   R_M};
            7'd18: u = '{OP_SUB,  R_M,    R_TZ,   R_KX};
            7'd19: u = '{OP_MUL,  R_A,    R_TY,   R_M};
            7'd20: u = '{OP_ADD,  R_TX,   R_M,    R_KY};
            7'd21: u = '{OP_SUB,  R_TX,   R_C,    R_M};
            7'd22: u = '{OP_MUL,  R_TZ,   R_M,    R_M};
            7'd23: u = '{OP_ADD,  R_B,    R_M,    R_KZ};
            7'd24: u = '{OP_ADD,  R_KX,   R_ZERO, R_SX};
            7'd25: u = '{OP_ADD,  R_KY,   R_ZERO, R_SY};
            7'd26: u = '{OP_ADD,  R_KZ,   R_ZERO, R_SZ};
            7'd27: u = '{OP_MUL,  R_H2,   R_KX,   R_M};
            7'd28: u = '{OP_ADD,  R_PX,   R_M,    R_TX};
            7'd29: u = '{OP_MUL,  R_H2,   R_KY,   R_M};
            7'd30: u = '{OP_ADD,  R_PY,   R_M,    R_TY};
            7'd31: u = '{OP_MUL,  R_H2,   R_KZ,   R_M};
            7'd32: u = '{OP_ADD,  R_PZ,   R_M,    R_TZ};
            // slope k3
            7'd33: u = '{OP_SUB,  R_ZERO, R_TY,   R_M};
            7'd34: u = '{OP_SUB,  R_M,    R_TZ,   R_KX};
            7'd35: u = '{OP_MUL,  R_A,    R_TY,   R_M};
            7'd36: u = '{OP_ADD,  R_TX,   R_M,    R_KY};
            7'd37: u = '{OP_SUB,  R_TX,   R_C,    R_M};
            7'd38: u = '{OP_MUL,  R_TZ,   R_M,    R_M};
            7'd39: u = '{OP_ADD,  R_B,    R_M,    R_KZ};
            7'd40: u = '{OP_ADD,  R_SX,   R_KX,   R_SX};
            7'd41: u = '{OP_ADD,  R_SY,   R_KY,   R_SY};
            7'd42: u = '{OP_ADD,  R_SZ,   R_KZ,   R_SZ};
            7'd43: u = '{OP_ADD,  R_SX,   R_SX,   R_SX};
            7'd44: u = '{OP_ADD,  R_SY,   R_SY,   R_SY};
            7'd45: u = '{OP_ADD,  R_SZ,   R_SZ,   R_SZ};
            7'd46: u = '{OP_ADD,  R_QX,   R_SX,   R_SX};
            7'd47: u = '{OP_ADD,  R_QY,   R_SY,   R_SY};
            7'd48: u = '{OP_ADD,  R_QZ,   R_SZ,   R_SZ};
            7'd49: u = '{OP_MUL,  R_H,    R_KX,   R_M};
            7'd50: u = '{OP_ADD,  R_PX,   R_M,    R_TX};
            7'd51: u = '{OP_MUL,  R_H,    R_KY,   R_M};
            7'd52: u = '{OP_ADD,  R_PY,   R_M,    R_TY};
            7'd53: u = '{OP_MUL,  R_H,    R_KZ,   R_M};
            7'd54: u = '{OP_ADD,  R_PZ,   R_M,    R_TZ};
            // slope k4 and the update
            7'd55: u = '{OP_SUB,  R_ZERO, R_TY,   R_M};
            7'd56: u = '{OP_SUB,  R_M,    R_TZ,   R_KX};
            7'd57: u = '{OP_MUL,  R_A,    R_TY,   R_M};
            7'd58: u = '{OP_ADD,  R_TX,   R_M,    R_KY};
            7'd59: u = '{OP_SUB,  R_TX,   R_C,    R_M};
            7'd60: u = '{OP_MUL,  R_TZ,   R_M,    R_M};
            7'd61: u = '{OP_ADD,  R_B,    R_M,    R_KZ};
            7'd62: u = '{OP_ADD,  R_SX,   R_KX,   R_SX};
            7'd63: u = '{OP_ADD,  R_SY,   R_KY,   R_SY};
            7'd64: u = '{OP_ADD,  R_SZ,   R_KZ,   R_SZ};
            7'd65: u = '{OP_MUL,  R_H6,   R_SX,   R_M};
            7'd66: u = '{OP_ADD,  R_PX,   R_M,    R_PX};
            7'd67: u = '{OP_MUL,  R_H6,   R_SY,   R_M};
            7'd68: u = '{OP_ADD,  R_PY,   R_M,    R_PY};
            7'd69: u = '{OP_MUL,  R_H6,   R_SZ,   R_M};
            7'd70: u = '{OP_ADD,  R_PZ,   R_M,    R_PZ};
            default: u = '{OP_ADD, R_ZERO, R_ZERO, R_M};
        endcase
        return u;
    endfunction

endpackage

[hdl/rrpt_alu.sv]
// Shared arithmetic unit: saturating add/sub, Q8.24 multiply, raw multiplies.
// Depends on rrpt_pkg.
module rrpt_alu (
    input  rrpt_pkg::alu_req_t req,
    output rrpt_pkg::alu_rsp_t rsp
);
    import rrpt_pkg::*;

    logic signed [DW:0]     a_s;
    logic signed [DW:0]     b_s;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] mulq;
    logic [DW:0]            sat_r;

    assign a_s  = $signed(req.a);
    assign b_s  = $signed(req.b);
    assign prod = a_s * b_s;
    assign mulq = prod >>> FB;

    always_comb
    begin
        sat_r = '0;
        unique case (req.opc)
            OP_ADD:  sat_r = sat_wide(PROD_W'(a_s) + PROD_W'(b_s));
            OP_SUB:  sat_r = sat_wide(PROD_W'(a_s) - PROD_W'(b_s));
            OP_MUL:  sat_r = sat_wide(mulq);
            OP_MULK: sat_r = {1'b0, prod[H6_SHIFT +: DW]};
            default: sat_r = '0;
        endcase
        rsp.res  = $signed(sat_r[DW-1:0]);
        rsp.ovf  = sat_r[DW];
        rsp.prod = prod;
    end

endmodule

[hdl/rrpt_div.sv]
// Restoring divider, one quotient bit per cycle, for the peak correction.
// Depends on rrpt_pkg.
module rrpt_div (
    input  logic              clk,
    input  logic              rst_n,
    input  rrpt_pkg::div_req_t req,
    output rrpt_pkg::div_rsp_t rsp
);
    import rrpt_pkg::*;

    localparam int CNT_W = $clog2(NUM_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_W - 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [NUM_W-1:0] num_reg;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    assign trial = {rem_reg, num_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            den_reg <= req.den;
            num_reg <= req.num;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            num_reg <= {num_reg[NUM_W-2:0], ge};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = num_reg;

endmodule

[hdl/rossler_rk4_peak_tracker.sv]
// Rossler RK4 integrator with peak tracking: sequencer, state and output register.
// A load goes straight to the output register; a step runs the microprogram on the shared unit,
// then the peak check and the output, and when a peak is found also one squaring and a bit-serial
// divide. One request at a time: the next is taken once the result is in the output register.
// rst_n clears the point, history, flags and sequencer state and restores the configuration.
// Depends on rrpt_pkg, rrpt_alu and rrpt_div.
module rossler_rk4_peak_tracker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  rrpt_pkg::in_item_t                   in_data,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output rrpt_pkg::out_item_t                  out_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [rrpt_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rrpt_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import rrpt_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RUN  = 3'd1;
    localparam logic [2:0] ST_PEAK = 3'd2;
    localparam logic [2:0] ST_SQ   = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    logic [2:0]           state_reg;
    logic [STEP_W-1:0]    step_reg;

    // configuration
    logic [GAIN_W-1:0]    c_reg;
    logic [GAIN_W-1:0]    a_reg;
    logic [GAIN_W-1:0]    b_reg;
    logic [STEP_SZ_W-1:0] h_reg;
    logic [AXIS_W-1:0]    axis_reg;

    // point and sample history
    logic signed [DW-1:0] px_reg, py_reg, pz_reg;
    logic signed [DW-1:0] older_reg, newer_reg;

    // working registers of the step
    logic signed [DW-1:0] tx_reg, ty_reg, tz_reg;
    logic signed [DW-1:0] kx_reg, ky_reg, kz_reg;
    logic signed [DW-1:0] qx_reg, qy_reg, qz_reg;
    logic signed [DW-1:0] sx_reg, sy_reg, sz_reg;
    logic signed [DW-1:0] m_reg;
    logic [STEP_SZ_W-1:0] h2_reg;
    logic [STEP_SZ_W-1:0] h6_reg;

    // peak refinement
    logic signed [DW-1:0] base_reg;
    logic [DW-1:0]        d_reg;
    logic [DEN_W-1:0]     den_reg;
    logic                 pk_found_reg;
    logic signed [DW-1:0] pk_val_reg;
    logic                 ovf_reg;

    logic                 out_valid_reg;
    out_item_t            out_data_reg;

    logic                 in_fire;
    logic                 fin_fire;
    uop_t                 cur_uop;
    logic [SEL_W-1:0]     sel [2];
    logic signed [DW:0]   opnd [2];
    alu_req_t             alu_req;
    alu_rsp_t             alu_rsp;
    div_req_t             div_req;
    div_rsp_t             div_rsp;

    logic signed [DW-1:0] init_watch;
    logic signed [DW-1:0] x2;
    logic                 peak_cond;
    logic signed [DW:0]   dd;
    logic signed [DW:0]   p_diff;
    logic signed [DW:0]   q_diff;
    logic [DW:0]          head_room;
    logic                 pk_sat;

    assign in_fire   = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign fin_fire  = (state_reg == ST_FIN) && (!out_valid_reg || !out_stall);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign cur_uop = prog_rom(step_reg);
    assign sel[0]  = cur_uop.sa;
    assign sel[1]  = cur_uop.sb;

    // Operand selection for the shared unit
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            unique case (sel[i])
                R_PX:    opnd[i] = {px_reg[DW-1], px_reg};
                R_PY:    opnd[i] = {py_reg[DW-1], py_reg};
                R_PZ:    opnd[i] = {pz_reg[DW-1], pz_reg};
                R_TX:    opnd[i] = {tx_reg[DW-1], tx_reg};
                R_TY:    opnd[i] = {ty_reg[DW-1], ty_reg};
                R_TZ:    opnd[i] = {tz_reg[DW-1], tz_reg};
                R_KX:    opnd[i] = {kx_reg[DW-1], kx_reg};
                R_KY:    opnd[i] = {ky_reg[DW-1], ky_reg};
                R_KZ:    opnd[i] = {kz_reg[DW-1], kz_reg};
                R_QX:    opnd[i] = {qx_reg[DW-1], qx_reg};
                R_QY:    opnd[i] = {qy_reg[DW-1], qy_reg};
                R_QZ:    opnd[i] = {qz_reg[DW-1], qz_reg};
                R_SX:    opnd[i] = {sx_reg[DW-1], sx_reg};
                R_SY:    opnd[i] = {sy_reg[DW-1], sy_reg};
                R_SZ:    opnd[i] = {sz_reg[DW-1], sz_reg};
                R_M:     opnd[i] = {m_reg[DW-1], m_reg};
                R_A:     opnd[i] = (DW+1)'(a_reg);
                R_B:     opnd[i] = (DW+1)'(b_reg);
                R_C:     opnd[i] = (DW+1)'(c_reg);
                R_H:     opnd[i] = (DW+1)'(h_reg);
                R_H2:    opnd[i] = (DW+1)'(h2_reg);
                R_H6:    opnd[i] = (DW+1)'(h6_reg);
                R_K6:    opnd[i] = (DW+1)'(K6_CONST);
                default: opnd[i] = '0;
            endcase
        end
    end

    // The squaring for the peak correction borrows the same multiplier
    always_comb
    begin
        if (state_reg == ST_SQ)
        begin
            alu_req.opc = OP_SQ;
            alu_req.a   = {1'b0, d_reg};
            alu_req.b   = {1'b0, d_reg};
        end
        else
        begin
            alu_req.opc = cur_uop.opc;
            alu_req.a   = opnd[0];
            alu_req.b   = opnd[1];
        end
    end

    rrpt_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    assign div_req.start = (state_reg == ST_SQ);
    assign div_req.num   = alu_rsp.prod[SQ_SHIFT +: NUM_W];
    assign div_req.den   = den_reg;

    rrpt_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Watched coordinate of a load and of the new point; axis code three watches z
    always_comb
    begin
        case (axis_reg)
            AXIS_X:
            begin
                init_watch = in_data.init_x;
                x2         = px_reg;
            end
            AXIS_Y:
            begin
                init_watch = in_data.init_y;
                x2         = py_reg;
            end
            default:
            begin
                init_watch = in_data.init_z;
                x2         = pz_reg;
            end
        endcase
    end

    // Peak test on the last three samples: older, newer, x2
    assign peak_cond = (older_reg < newer_reg) && (newer_reg > x2);
    assign dd        = {x2[DW-1], x2} - {older_reg[DW-1], older_reg};
    assign p_diff    = {newer_reg[DW-1], newer_reg} - {older_reg[DW-1], older_reg};
    assign q_diff    = {newer_reg[DW-1], newer_reg} - {x2[DW-1], x2};

    // Correction is never negative: only the upper limit can saturate
    assign head_room = {1'b0, MAX_POS} - {base_reg[DW-1], base_reg};
    assign pk_sat    = div_rsp.quo > NUM_W'(head_room);

    // Sequencer, point, history and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            c_reg         <= C_RESET;
            a_reg         <= A_RESET;
            b_reg         <= B_RESET;
            h_reg         <= STEP_RESET;
            axis_reg      <= AXIS_Z;
            px_reg        <= '0;
            py_reg        <= '0;
            pz_reg        <= '0;
            older_reg     <= '0;
            newer_reg     <= '0;
            pk_found_reg  <= 1'b0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_C_GAIN:   c_reg    <= cfg_data[GAIN_W-1:0];
                    CFG_A_GAIN:   a_reg    <= cfg_data[GAIN_W-1:0];
                    CFG_B_OFFSET: b_reg    <= cfg_data[GAIN_W-1:0];
                    CFG_STEP:     h_reg    <= cfg_data[STEP_SZ_W-1:0];
                    CFG_AXIS:     axis_reg <= cfg_data[AXIS_W-1:0];
                    default:      ;
                endcase
            end

            if (fin_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        ovf_reg      <= 1'b0;
                        pk_found_reg <= 1'b0;
                        step_reg     <= '0;
                        if (!in_data.op)
                        begin
                            // load: set the point and fill the history
                            px_reg    <= in_data.init_x;
                            py_reg    <= in_data.init_y;
                            pz_reg    <= in_data.init_z;
                            older_reg <= init_watch;
                            newer_reg <= init_watch;
                            state_reg <= ST_FIN;
                        end
                        else
                        begin
                            state_reg <= ST_RUN;
                        end
                    end
                end
                ST_RUN:
                begin
                    ovf_reg <= ovf_reg | alu_rsp.ovf;
                    unique case (cur_uop.dst)
                        R_PX:    px_reg <= alu_rsp.res;
                        R_PY:    py_reg <= alu_rsp.res;
                        R_PZ:    pz_reg <= alu_rsp.res;
                        default: ;
                    endcase
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == LAST_STEP)
                    begin
                        state_reg <= ST_PEAK;
                    end
                end
                ST_PEAK:
                begin
                    // shift the history, always
                    older_reg    <= newer_reg;
                    newer_reg    <= x2;
                    pk_found_reg <= peak_cond;
                    state_reg    <= peak_cond ? ST_SQ : ST_FIN;
                end
                ST_SQ:
                begin
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        ovf_reg   <= ovf_reg | pk_sat;
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    if (fin_fire)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Working registers of the step and peak datapath
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            tx_reg     <= px_reg;
            ty_reg     <= py_reg;
            tz_reg     <= pz_reg;
            h2_reg     <= h_reg >> 1;
            pk_val_reg <= '0;
        end
        else if (state_reg == ST_RUN)
        begin
            unique case (cur_uop.dst)
                R_TX:    tx_reg <= alu_rsp.res;
                R_TY:    ty_reg <= alu_rsp.res;
                R_TZ:    tz_reg <= alu_rsp.res;
                R_KX:    kx_reg <= alu_rsp.res;
                R_KY:    ky_reg <= alu_rsp.res;
                R_KZ:    kz_reg <= alu_rsp.res;
                R_QX:    qx_reg <= alu_rsp.res;
                R_QY:    qy_reg <= alu_rsp.res;
                R_QZ:    qz_reg <= alu_rsp.res;
                R_SX:    sx_reg <= alu_rsp.res;
                R_SY:    sy_reg <= alu_rsp.res;
                R_SZ:    sz_reg <= alu_rsp.res;
                R_M:     m_reg  <= alu_rsp.res;
                R_H6:    h6_reg <= alu_rsp.res[STEP_SZ_W-1:0];
                default: ;
            endcase
        end
        else if (state_reg == ST_PEAK)
        begin
            base_reg   <= newer_reg;
            d_reg      <= dd[DW] ? DW'(-dd) : dd[DW-1:0];
            den_reg    <= DEN_W'($unsigned(p_diff)) + DEN_W'($unsigned(q_diff));
            pk_val_reg <= '0;
        end
        else if (state_reg == ST_DIV && div_rsp.done)
        begin
            pk_val_reg <= pk_sat ? $signed(MAX_POS) : base_reg + $signed(div_rsp.quo[DW-1:0]);
        end
    end

    // Output register: hold until taken
    always_ff @(posedge clk)
    begin
        if (fin_fire)
        begin
            out_data_reg.new_x      <= px_reg;
            out_data_reg.new_y      <= py_reg;
            out_data_reg.new_z      <= pz_reg;
            out_data_reg.peak_found <= pk_found_reg;
            out_data_reg.peak_value <= pk_val_reg;
            out_data_reg.overflow   <= ovf_reg;
        end
    end

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> state_reg != ST_IDLE)
        else $error("accepted request did not start the sequencer");

    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> state_reg == ST_DIV)
        else $error("divider finished outside its wait state");

    a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_FIN)
        else $error("result appeared without finishing a request");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN |-> step_reg <= LAST_STEP)
        else $error("microprogram counter ran past the last step");

endmodule
